// File: rtl/ident_number_hash_lexer_defines.svh
// assertion macros shared by the lexer checks
// no dependencies; included by the checker file
`ifndef IDENT_NUMBER_HASH_LEXER_DEFINES_SVH
`define IDENT_NUMBER_HASH_LEXER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IHL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ihl check failed");

// next-cycle implication, disabled while reset is asserted
`define IHL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ihl check failed");

`endif

// File: rtl/ihl_pkg.sv
`timescale 1ns / 1ps
// types and constants for the identifier / number / hash lexer
// no dependencies; used by the scanner, the queue, the top level, the checker and the testbench
package ihl_pkg;

	localparam int IHL_OFFSET_BITS = 20;
	localparam int IHL_LINE_BITS   = 16;

	// widths of the result fields on the port
	localparam int OFF_W  = 20;
	localparam int LINE_W = 16;
	localparam int KIND_W = 3;

	localparam logic [KIND_W-1:0] KIND_IDENT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NUM   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_HASH  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DHASH = 3'd3;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERROR = 3'd5;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [OFF_W-1:0]  start_offset;
		logic [OFF_W-1:0]  token_length;
		logic [LINE_W-1:0] start_line;
		logic [LINE_W-1:0] start_column;
		logic [7:0]        bad_byte;
		logic              last;
	} res_t;

	// up to two results from one byte, in order
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

// File: rtl/ihl_in_if.sv
`timescale 1ns / 1ps
// byte channel of the lexer: valid / ready plus one source byte or end marker
// no dependencies
interface ihl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// File: rtl/ihl_out_if.sv
`timescale 1ns / 1ps
// token channel of the lexer: valid / ready plus the result fields
// no dependencies
interface ihl_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [19:0] start_offset;
	logic [19:0] token_length;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [7:0]  bad_byte;
	logic        last;

	modport source (output valid, output token_kind, output start_offset,
		output token_length, output start_line, output start_column,
		output bad_byte, output last, input ready);
	modport sink (input valid, input token_kind, input start_offset,
		input token_length, input start_line, input start_column,
		input bad_byte, input last, output ready);
endinterface

// File: rtl/ihl_scan.sv
`timescale 1ns / 1ps
// input register, scanner state and per-byte classification
// depends on ihl_pkg
module ihl_scan
	import ihl_pkg::*;
#(
	parameter int OFFSET_BITS = IHL_OFFSET_BITS,
	parameter int LINE_BITS   = IHL_LINE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	input  logic       room,
	output logic       busy,
	output push_t      push
);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUM    = 3'd2;
	localparam logic [2:0] MODE_HASH   = 3'd3;
	localparam logic [2:0] MODE_FAILED = 3'd4;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       fire;

	logic [2:0]             mode_q, mode_d;
	logic                   cr_q, cr_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, tstart_q, tstart_d;
	logic [LINE_BITS-1:0]   line_q, line_d, col_q, col_d;
	logic [LINE_BITS-1:0]   tline_q, tline_d, tcol_q, tcol_d;

	logic [OFFSET_BITS-1:0] off_inc;
	logic [LINE_BITS-1:0]   line_inc, col_inc;
	logic [OFFSET_BITS-1:0] span;
	logic cls_word, cls_dec, is_hash, is_blank, is_break, lf_skip, tok_open;
	logic flush_v, tail_v;
	res_t flush_r, tail_r;

	function automatic logic [OFF_W-1:0] fit_off(input logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[OFF_W-1:0];
	endfunction

	function automatic logic [LINE_W-1:0] fit_line(input logic [LINE_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[LINE_W-1:0];
	endfunction

	assign fire = valid_s1 && room;
	assign busy = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	assign cls_word = (byte_s1 >= 8'h41 && byte_s1 <= 8'h5A) ||
		(byte_s1 >= 8'h61 && byte_s1 <= 8'h7A) || byte_s1 == CH_UNDER;
	assign cls_dec  = byte_s1 >= 8'h30 && byte_s1 <= 8'h39;
	assign is_hash  = byte_s1 == CH_HASH;
	assign is_blank = byte_s1 == CH_SPACE || byte_s1 == CH_TAB;
	assign is_break = byte_s1 == CH_LF || byte_s1 == CH_CR;
	assign lf_skip  = cr_q && byte_s1 == CH_LF;
	assign tok_open = mode_q == MODE_IDENT || mode_q == MODE_NUM || mode_q == MODE_HASH;

	// saturating counters
	assign off_inc  = (off_q == OFF_MAX) ? off_q : off_q + OFFSET_BITS'(1);
	assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_ONE;
	assign col_inc  = (col_q == LINE_MAX) ? col_q : col_q + LINE_ONE;
	assign span     = (off_q >= tstart_q) ? off_q - tstart_q : '0;

	// the token that a byte or the end marker closes
	always_comb begin
		flush_r = '0;
		unique case (mode_q)
			MODE_IDENT: flush_r.token_kind = KIND_IDENT;
			MODE_NUM:   flush_r.token_kind = KIND_NUM;
			MODE_HASH:  flush_r.token_kind = KIND_HASH;
			default:    flush_r.token_kind = KIND_IDENT;
		endcase
		flush_r.start_offset = fit_off(tstart_q);
		flush_r.token_length = (mode_q == MODE_HASH) ? OFF_W'(1) : fit_off(span);
		flush_r.start_line   = fit_line(tline_q);
		flush_r.start_column = fit_line(tcol_q);
	end

	always_comb begin
		mode_d   = mode_q;
		cr_d     = cr_q;
		off_d    = off_q;
		line_d   = line_q;
		col_d    = col_q;
		tstart_d = tstart_q;
		tline_d  = tline_q;
		tcol_d   = tcol_q;
		flush_v  = 1'b0;
		tail_v   = 1'b0;
		tail_r   = '0;
		tail_r.start_offset = fit_off(off_q);
		tail_r.start_line   = fit_line(line_q);
		tail_r.start_column = fit_line(col_q);

		if (mode_q != MODE_FAILED) begin
			if (eoi_s1) begin
				flush_v           = tok_open;
				tail_v            = 1'b1;
				tail_r.token_kind = KIND_END;
				mode_d   = MODE_IDLE;
				cr_d     = 1'b0;
				off_d    = '0;
				line_d   = LINE_ONE;
				col_d    = LINE_ONE;
				tstart_d = '0;
				tline_d  = LINE_ONE;
				tcol_d   = LINE_ONE;
			end else begin
				cr_d = 1'b0;
				priority if ((mode_q == MODE_IDENT && (cls_word || cls_dec)) ||
					(mode_q == MODE_NUM && cls_dec)) begin
					off_d = off_inc;
					col_d = col_inc;
				end else if (mode_q == MODE_HASH && is_hash) begin
					tail_v              = 1'b1;
					tail_r              = flush_r;
					tail_r.token_kind   = KIND_DHASH;
					tail_r.token_length = OFF_W'(2);
					off_d  = off_inc;
					col_d  = col_inc;
					mode_d = MODE_IDLE;
				end else begin
					// close any open token, then treat the byte as if idle
					flush_v = tok_open;
					mode_d  = MODE_IDLE;
					priority if (lf_skip) begin
						off_d = off_inc;
					end else if (is_blank) begin
						off_d = off_inc;
						col_d = col_inc;
					end else if (is_break) begin
						off_d  = off_inc;
						line_d = line_inc;
						col_d  = LINE_ONE;
						cr_d   = byte_s1 == CH_CR;
					end else if (cls_word || cls_dec || is_hash) begin
						mode_d   = cls_word ? MODE_IDENT : (cls_dec ? MODE_NUM : MODE_HASH);
						tstart_d = off_q;
						tline_d  = line_q;
						tcol_d   = col_q;
						off_d    = off_inc;
						col_d    = col_inc;
					end else begin
						tail_v            = 1'b1;
						tail_r.token_kind = KIND_ERROR;
						tail_r.bad_byte   = byte_s1;
						mode_d            = MODE_FAILED;
					end
				end
			end
		end
	end

	always_comb begin
		push = '0;
		if (flush_v) begin
			push.v0      = fire;
			push.r0      = flush_r;
			push.r0.last = !tail_v;
			push.v1      = fire && tail_v;
			push.r1      = tail_r;
			push.r1.last = 1'b1;
		end else begin
			push.v0      = fire && tail_v;
			push.r0      = tail_r;
			push.r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			cr_q     <= 1'b0;
			off_q    <= '0;
			line_q   <= LINE_ONE;
			col_q    <= LINE_ONE;
			tstart_q <= '0;
			tline_q  <= LINE_ONE;
			tcol_q   <= LINE_ONE;
		end else if (fire) begin
			mode_q   <= mode_d;
			cr_q     <= cr_d;
			off_q    <= off_d;
			line_q   <= line_d;
			col_q    <= col_d;
			tstart_q <= tstart_d;
			tline_q  <= tline_d;
			tcol_q   <= tcol_d;
		end
	end

endmodule

// File: rtl/ihl_outq.sv
`timescale 1ns / 1ps
// four-entry result queue: takes up to two results a cycle, hands out one while the token channel is ready
// depends on ihl_pkg and ihl_out_if
module ihl_outq
	import ihl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	output logic             room,
	ihl_out_if.source        token_ch
);

	res_t       mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] n_push;
	res_t       head;

	assign n_push = 2'(push.v0) + 2'(push.v1);
	assign pop    = count_q != 3'd0 && token_ch.ready;
	// room for a full pair regardless of this cycle's pop
	assign room   = count_q <= 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push;
			rd_q    <= rd_q + 2'(pop);
			count_q <= count_q + 3'(n_push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem[wr_q + 2'd1] <= push.r1;
		end
	end

	assign head                  = mem[rd_q];
	assign token_ch.valid        = count_q != 3'd0;
	assign token_ch.token_kind   = head.token_kind;
	assign token_ch.start_offset = head.start_offset;
	assign token_ch.token_length = head.token_length;
	assign token_ch.start_line   = head.start_line;
	assign token_ch.start_column = head.start_column;
	assign token_ch.bad_byte     = head.bad_byte;
	assign token_ch.last         = head.last;

endmodule

// File: rtl/ident_number_hash_lexer.sv
`timescale 1ns / 1ps
// identifier / number / hash lexer, top level
// a result passes the input register and then the result queue before it is valid on the token channel
// throughput: one byte per cycle; the four-entry result queue stalls input when it holds
// more than two results, so sustained output is one result per cycle while the token channel is ready
// reset: arst_n clears to offset 0, line 1, column 1, idle, and empties the queue
// depends on ihl_pkg, ihl_in_if, ihl_out_if, ihl_scan, ihl_outq
module ident_number_hash_lexer
	import ihl_pkg::*;
#(
	parameter int OFFSET_BITS = IHL_OFFSET_BITS,
	parameter int LINE_BITS   = IHL_LINE_BITS
) (
	input logic       clk,
	input logic       arst_n,
	ihl_in_if.sink    byte_ch,
	ihl_out_if.source token_ch
);

	logic  busy;
	logic  room;
	logic  load;
	push_t push;

	assign byte_ch.ready = !busy || room;
	assign load          = byte_ch.valid && byte_ch.ready;

	ihl_scan #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS(LINE_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.in_byte(byte_ch.in_byte),
		.end_of_input(byte_ch.end_of_input),
		.room(room),
		.busy(busy),
		.push(push)
	);

	ihl_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.token_ch(token_ch)
	);

endmodule

// File: rtl/ihl_checker.sv
`timescale 1ns / 1ps
// port-level checks on the lexer result channel, bound to the top level
// depends on ihl_pkg and ident_number_hash_lexer_defines.svh
`include "ident_number_hash_lexer_defines.svh"

module ihl_checker
	import ihl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  token_kind,
	input logic [19:0] start_offset,
	input logic [19:0] token_length,
	input logic [7:0]  bad_byte,
	input logic        last
);

	`IHL_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(start_offset))
	`IHL_ASSERT_SAME(a_end_last, clk, arst_n, out_valid && (token_kind == KIND_END || token_kind == KIND_ERROR), last && token_length == 20'd0)
	`IHL_ASSERT_SAME(a_dhash_len, clk, arst_n, out_valid && token_kind == KIND_DHASH, token_length == 20'd2)
	`IHL_ASSERT_SAME(a_bad_zero, clk, arst_n, out_valid && token_kind != KIND_ERROR, bad_byte == 8'd0)

endmodule

bind ident_number_hash_lexer ihl_checker u_ihl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(token_ch.valid),
	.out_ready(token_ch.ready),
	.token_kind(token_ch.token_kind),
	.start_offset(token_ch.start_offset),
	.token_length(token_ch.token_length),
	.bad_byte(token_ch.bad_byte),
	.last(token_ch.last)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for the identifier / number / hash lexer: drives byte streams and
// predicts every token, checking each one as it leaves the token channel
// depends on ihl_pkg, ihl_in_if, ihl_out_if and ident_number_hash_lexer
module tb;
	import ihl_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_IDENT,
		SCAN_NUM,
		SCAN_HASH,
		SCAN_FAILED
	} scan_mode_t;

	class lexer_scoreboard;
		scan_mode_t        mode;
		logic              cr_seen;
		logic [OFF_W-1:0]  offset;
		logic [OFF_W-1:0]  tok_start;
		logic [LINE_W-1:0] line;
		logic [LINE_W-1:0] column;
		logic [LINE_W-1:0] tok_line;
		logic [LINE_W-1:0] tok_column;
		res_t              step_out[$];
		res_t              pending_tokens[$];
		int unsigned       mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			mode = SCAN_IDLE;
			cr_seen = 1'b0;
			offset = '0;
			tok_start = '0;
			line = LINE_W'(1);
			column = LINE_W'(1);
			tok_line = LINE_W'(1);
			tok_column = LINE_W'(1);
		endfunction

		function bit is_word_start(logic [7:0] b);
			return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == CH_UNDER;
		endfunction

		function bit is_dec_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function bit is_legal(logic [7:0] b);
			return is_word_start(b) || is_dec_digit(b) || b == CH_HASH || b == CH_SPACE
				|| b == CH_TAB || b == CH_CR || b == CH_LF;
		endfunction

		function logic [OFF_W-1:0] bump_offset(logic [OFF_W-1:0] v);
			return (v == {OFF_W{1'b1}}) ? v : v + 1'b1;
		endfunction

		function logic [LINE_W-1:0] bump_line(logic [LINE_W-1:0] v);
			return (v == {LINE_W{1'b1}}) ? v : v + 1'b1;
		endfunction

		function void step_column();
			offset = bump_offset(offset);
			column = bump_line(column);
		endfunction

		function res_t make_token(logic [KIND_W-1:0] kind, logic [OFF_W-1:0] start,
			logic [OFF_W-1:0] len, logic [LINE_W-1:0] ln, logic [LINE_W-1:0] col,
			logic [7:0] bad);
			res_t r;
			r.token_kind = kind;
			r.start_offset = start;
			r.token_length = len;
			r.start_line = ln;
			r.start_column = col;
			r.bad_byte = bad;
			r.last = 1'b0;
			return r;
		endfunction

		function void open_token(scan_mode_t m);
			mode = m;
			tok_start = offset;
			tok_line = line;
			tok_column = column;
			step_column();
		endfunction

		function void flush_token();
			logic [KIND_W-1:0] kind;
			logic [OFF_W-1:0]  len;
			if (mode == SCAN_IDLE || mode == SCAN_FAILED)
				return;
			// length undercounts once the offset is pinned at its maximum
			len = (offset >= tok_start) ? offset - tok_start : '0;
			case (mode)
				SCAN_IDENT: kind = KIND_IDENT;
				SCAN_NUM: kind = KIND_NUM;
				default: begin
					kind = KIND_HASH;
					len = OFF_W'(1);
				end
			endcase
			step_out.push_back(make_token(kind, tok_start, len, tok_line, tok_column, 8'h00));
			mode = SCAN_IDLE;
		endfunction

		// one accepted transfer on the byte channel
		function void note_byte(logic [7:0] b, logic eoi);
			logic lf_skip;
			res_t t;
			step_out.delete();
			if (mode == SCAN_FAILED)
				return;
			if (eoi) begin
				flush_token();
				step_out.push_back(make_token(KIND_END, offset, '0, line, column, 8'h00));
				restart();
			end else begin
				lf_skip = cr_seen && b == CH_LF;
				cr_seen = 1'b0;
				if (mode == SCAN_IDENT && (is_word_start(b) || is_dec_digit(b))) begin
					step_column();
				end else if (mode == SCAN_NUM && is_dec_digit(b)) begin
					step_column();
				end else if (mode == SCAN_HASH && b == CH_HASH) begin
					step_out.push_back(make_token(KIND_DHASH, tok_start, OFF_W'(2), tok_line,
						tok_column, 8'h00));
					step_column();
					mode = SCAN_IDLE;
				end else begin
					// the ending byte is handled as if nothing were pending
					flush_token();
					if (lf_skip) begin
						offset = bump_offset(offset);
					end else if (b == CH_SPACE || b == CH_TAB) begin
						step_column();
					end else if (b == CH_LF || b == CH_CR) begin
						offset = bump_offset(offset);
						line = bump_line(line);
						column = LINE_W'(1);
						cr_seen = (b == CH_CR);
					end else if (is_word_start(b)) begin
						open_token(SCAN_IDENT);
					end else if (is_dec_digit(b)) begin
						open_token(SCAN_NUM);
					end else if (b == CH_HASH) begin
						open_token(SCAN_HASH);
					end else begin
						step_out.push_back(make_token(KIND_ERROR, offset, '0, line, column, b));
						mode = SCAN_FAILED;
					end
				end
			end
			foreach (step_out[i]) begin
				t = step_out[i];
				t.last = (i == step_out.size() - 1);
				pending_tokens.push_back(t);
			end
		endfunction

		function string show(res_t r);
			return $sformatf("kind=%0d off=%0d len=%0d line=%0d col=%0d bad=%02h last=%0d",
				r.token_kind, r.start_offset, r.token_length, r.start_line,
				r.start_column, r.bad_byte, r.last);
		endfunction

		// one accepted transfer on the token channel
		function void check_token(res_t got);
			res_t want;
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: token with none expected: %s", show(got));
				return;
			end
			want = pending_tokens.pop_front();
			if (got.token_kind !== want.token_kind || got.start_offset !== want.start_offset
				|| got.token_length !== want.token_length
				|| got.start_line !== want.start_line
				|| got.start_column !== want.start_column
				|| got.bad_byte !== want.bad_byte || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: token mismatch at %0t", $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   send_gap_pct = 0;
	int   recv_stall_pct = 0;
	int   items_sent = 0;
	int unsigned cycle_count = 0;
	lexer_scoreboard sb;

	ihl_in_if  byte_ch ();
	ihl_out_if token_ch ();

	ident_number_hash_lexer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.token_ch (token_ch)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk) begin
		token_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	always @(posedge clk) begin : monitor
		res_t got;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			got.token_kind = token_ch.token_kind;
			got.start_offset = token_ch.start_offset;
			got.token_length = token_ch.token_length;
			got.start_line = token_ch.start_line;
			got.start_column = token_ch.start_column;
			got.bad_byte = token_ch.bad_byte;
			got.last = token_ch.last;
			sb.check_token(got);
		end
		if (arst_n && byte_ch.valid && byte_ch.ready)
			sb.note_byte(byte_ch.in_byte, byte_ch.end_of_input);
	end

	// valid stays high from one transfer to the next unless a gap is drawn
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.in_byte = b;
		byte_ch.end_of_input = eoi;
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	function automatic logic [7:0] random_word_start();
		int r;
		r = $urandom_range(52, 0);
		if (r < 26)
			return 8'("A" + r);
		if (r < 52)
			return 8'("a" + (r - 26));
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] random_digit();
		return 8'("0" + $urandom_range(9, 0));
	endfunction

	function automatic logic [7:0] random_word_char();
		return ($urandom_range(62, 0) < 10) ? random_digit() : random_word_start();
	endfunction

	function automatic logic [7:0] random_legal_byte();
		case ($urandom_range(5, 0))
			0, 1: return random_word_char();
			2: return CH_HASH;
			3: return CH_SPACE;
			4: return CH_TAB;
			default: return $urandom_range(1, 0) ? CH_CR : CH_LF;
		endcase
	endfunction

	// one well-formed piece of source text, a stray legal byte, or a stream end
	task automatic send_piece();
		int pick;
		int n;
		pick = $urandom_range(99, 0);
		n = 0;
		if (pick < 30) begin
			send_byte(random_word_start(), 1'b0);
			n = $urandom_range(10, 0);
			repeat (n) send_byte(random_word_char(), 1'b0);
		end else if (pick < 50) begin
			n = $urandom_range(6, 1);
			repeat (n) send_byte(random_digit(), 1'b0);
		end else if (pick < 60) begin
			n = $urandom_range(3, 1);
			repeat (n) send_byte(CH_HASH, 1'b0);
		end else if (pick < 85) begin
			case ($urandom_range(4, 0))
				0: send_byte(CH_SPACE, 1'b0);
				1: send_byte(CH_TAB, 1'b0);
				2: send_byte(CH_LF, 1'b0);
				3: send_byte(CH_CR, 1'b0);
				default: send_text("\r\n");
			endcase
		end else if (pick < 95) begin
			send_byte(random_legal_byte(), 1'b0);
		end else begin
			send_byte(8'($urandom_range(255, 0)), 1'b1);
		end
	endtask

	task automatic run_random(input int gap, input int stall, input int count);
		int stop_at;
		send_gap_pct = gap;
		recv_stall_pct = stall;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			send_piece();
	endtask

	initial begin
		logic [7:0] bad;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = 8'h00;
		byte_ch.end_of_input = 1'b0;
		token_ch.ready = 1'b0;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every token kind but error, line break forms, triple hash, flush at stream end
		send_text("_a9 42\t#x##\r\n###1\r\r\nZ");
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		send_text("#");
		send_byte(8'h80, 1'b1);

		run_random(0, 0, 125);
		run_random(74, 0, 125);
		run_random(0, 74, 125);
		run_random(16, 16, 125);
		send_byte(8'($urandom_range(255, 0)), 1'b1);

		// mixed tokens ended by a newline, then an identifier flushed at stream end
		send_gap_pct = 0;
		recv_stall_pct = 0;
		send_text("abcdefghij 7 ## #\n_");
		send_byte(8'h00, 1'b1);

		// token cut short by a bad byte; everything after is swallowed
		send_gap_pct = 16;
		recv_stall_pct = 16;
		send_text("q");
		do bad = 8'($urandom_range(255, 0)); while (sb.is_legal(bad));
		send_byte(bad, 1'b0);
		send_text("ab#");
		send_byte(8'h00, 1'b1);
		send_text("x");
		@(negedge clk);
		byte_ch.valid = 1'b0;

		while (sb.pending_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
